/* design/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and character helpers for the token boundary scanner
// Phase and sub-step codes, token kinds, scanner control word, byte classes.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam logic [3:0] KW_LEN = 4'd9;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LBRC  = 8'h7B;

  typedef enum logic [1:0] {PH_IDLE, PH_TERM, PH_BODY, PH_VALUE} phase_t;
  typedef enum logic [1:0] {T_SKIP, T_COMMENT, T_RUN} term_sub_t;
  typedef enum logic [2:0] {B_LEAD, B_WS, B_KW, B_AFTER, B_LINE} body_sub_t;
  typedef enum logic [1:0] {U_LEAD, U_Q2, U_MAIN, U_STR} value_sub_t;
  typedef enum logic [1:0] {TK_NONE, TK_TERM, TK_BODY, TK_VALUE} kind_t;

  typedef struct packed {
    phase_t     phase;
    term_sub_t  term_sub;
    body_sub_t  body_sub;
    value_sub_t value_sub;
    logic [2:0] kinds;
    logic [3:0] kw_idx;
    logic       raw_seen;
    logic       space_waiting;
    logic       last_was_word;
    logic       content_seen;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase: PH_IDLE, term_sub: T_SKIP, body_sub: B_LEAD, value_sub: U_LEAD,
    kinds: 3'd0, kw_idx: 4'd0, raw_seen: 1'b0, space_waiting: 1'b0,
    last_was_word: 1'b0, content_seen: 1'b0
  };

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

  function automatic logic opens_bracket(input logic [7:0] c);
    return (c == CH_LBRC) || (c == CH_LBRK) || (c == CH_LPAR);
  endfunction

  function automatic logic value_stop(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR) || (c == CH_SEMI) || (c == CH_PCT) ||
           (c == CH_COMMA) || (c == CH_RPAR) || (c == CH_NUL);
  endfunction

  // closing keyword of a script body, one letter per index
  function automatic logic [7:0] kw_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0:    r = 8'h45; // E
      4'd1:    r = 8'h6E; // n
      4'd2:    r = 8'h64; // d
      4'd3:    r = 8'h53; // S
      4'd4:    r = 8'h63; // c
      4'd5:    r = 8'h72; // r
      4'd6:    r = 8'h69; // i
      4'd7:    r = 8'h70; // p
      4'd8:    r = 8'h74; // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* design/stbs_step.sv */
// ----------------------------------------------------------------------------
// stbs_step: single-byte scanner step
// Given the scanner state and one byte, works out the next state and whether
// the scan attempt ends here, with the token kind and offsets.
// ----------------------------------------------------------------------------
module stbs_step #(
  parameter int OFFSET_BITS = stbs_pkg::OFFSET_BITS_DEF
) (
  input  stbs_pkg::ctl_t         ctl,
  input  logic [OFFSET_BITS-1:0] position,
  input  logic [OFFSET_BITS-1:0] start_offset,
  input  logic [OFFSET_BITS-1:0] marked_end,
  input  logic                   scan_start,
  input  logic [2:0]             valid_kinds,
  input  logic [7:0]             char_code,
  output stbs_pkg::ctl_t         ctl_next,
  output logic [OFFSET_BITS-1:0] position_next,
  output logic [OFFSET_BITS-1:0] start_offset_next,
  output logic [OFFSET_BITS-1:0] marked_end_next,
  output logic                   res_valid,
  output stbs_pkg::kind_t        res_kind,
  output logic [15:0]            res_start,
  output logic [15:0]            res_end
);
  import stbs_pkg::*;

  ctl_t                   c;
  logic                   cons, skip, done, gup, w;
  kind_t                  kind;
  logic [OFFSET_BITS-1:0] pos_base, so_base, me, pos_inc;
  logic [7:0]             b;

  function automatic ctl_t enter(input ctl_t s, input phase_t p);
    ctl_t r;
    r = CTL_RESET;
    r.kinds = s.kinds;
    r.phase = p;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] ext;
    ext = {16'd0, v};
    return (ext > (OFFSET_BITS+16)'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  assign b = char_code;

  // next state: phases cascade in order, each one picking up where the last stopped
  always_comb begin
    c    = ctl;
    cons = 1'b0;
    skip = 1'b0;
    done = 1'b0;
    gup  = 1'b0;
    w    = 1'b0;
    kind = TK_NONE;
    pos_base = scan_start ? '0 : position;
    so_base  = scan_start ? '0 : start_offset;
    me       = scan_start ? '0 : marked_end;
    pos_inc  = (&pos_base) ? pos_base : pos_base + OFFSET_BITS'(1);

    if (scan_start) begin
      c = CTL_RESET;
      c.kinds = valid_kinds;
      if (valid_kinds[0])      c = enter(c, PH_TERM);
      else if (valid_kinds[1]) c = enter(c, PH_BODY);
      else if (valid_kinds[2]) c = enter(c, PH_VALUE);
      else                     done = 1'b1;
    end

    // statement terminator
    if (!done && c.phase == PH_TERM) begin
      gup = 1'b0;
      if (c.term_sub == T_SKIP) begin
        if (is_blank(b) || b == CH_CR) begin
          cons = 1'b1; skip = 1'b1;
        end else if (b == CH_PCT) begin
          cons = 1'b1; skip = 1'b1; c.term_sub = T_COMMENT;
        end else if (b != CH_SEMI && b != CH_LF && b != CH_NUL) begin
          gup = 1'b1;
        end else begin
          c.term_sub = T_RUN;
        end
      end else if (c.term_sub == T_COMMENT) begin
        if (b != CH_LF && b != CH_NUL) begin
          cons = 1'b1; skip = 1'b1;
        end else begin
          c.term_sub = T_RUN;
        end
      end
      if (!cons && !gup && c.term_sub == T_RUN) begin
        if (b == CH_SEMI || b == CH_LF || b == CH_CR || is_blank(b)) begin
          cons = 1'b1;
        end else begin
          me = pos_base; done = 1'b1; kind = TK_TERM;
        end
      end
      if (gup) begin
        if (c.kinds[1])      c = enter(c, PH_BODY);
        else if (c.kinds[2]) c = enter(c, PH_VALUE);
        else                 done = 1'b1;
      end
    end

    // script body
    if (!done && !cons && c.phase == PH_BODY) begin
      gup = 1'b0;
      if (c.body_sub == B_LEAD) begin
        if (is_blank(b) || b == CH_CR || b == CH_LF) begin
          cons = 1'b1; skip = 1'b1;
        end else if (b == CH_NUL) begin
          gup = 1'b1;
        end else begin
          me = pos_base; c.body_sub = B_WS;
        end
      end
      if (!cons && !gup && c.body_sub == B_WS) begin
        if (is_blank(b)) begin
          cons = 1'b1;
        end else begin
          c.kw_idx = 4'd0; c.body_sub = B_KW;
        end
      end
      if (!cons && !gup && c.body_sub == B_KW) begin
        if (c.kw_idx < KW_LEN && b == kw_char(c.kw_idx)) begin
          cons = 1'b1;
          c.kw_idx = c.kw_idx + 4'd1;
          if (c.kw_idx >= KW_LEN) c.body_sub = B_AFTER;
        end else begin
          c.body_sub = B_LINE;
        end
      end
      if (!cons && !gup && c.body_sub == B_AFTER) begin
        if (!is_wordch(b)) begin
          if (!c.content_seen) gup = 1'b1;
          else begin
            done = 1'b1; kind = TK_BODY;
          end
        end else begin
          c.body_sub = B_LINE;
        end
      end
      if (!cons && !gup && !done && c.body_sub == B_LINE) begin
        if (b == CH_NUL) begin
          me = pos_base;
          if (!c.content_seen) gup = 1'b1;
          else begin
            done = 1'b1; kind = TK_BODY;
          end
        end else begin
          cons = 1'b1;
          c.content_seen = 1'b1;
          if (b == CH_LF) begin
            me = pos_inc; c.body_sub = B_WS;
          end
        end
      end
      if (gup) begin
        if (c.kinds[2]) c = enter(c, PH_VALUE);
        else            done = 1'b1;
      end
    end

    // unquoted value
    if (!done && !cons && c.phase == PH_VALUE) begin
      gup = 1'b0;
      if (c.value_sub == U_LEAD) begin
        if (is_blank(b)) begin
          cons = 1'b1; skip = 1'b1;
        end else if (value_stop(b) || opens_bracket(b)) begin
          gup = 1'b1;
        end else if (b == CH_QUOTE) begin
          cons = 1'b1; c.value_sub = U_Q2;
        end else begin
          c.value_sub = U_MAIN;
        end
      end
      if (!cons && !gup && c.value_sub == U_Q2) begin
        if (b != CH_QUOTE) gup = 1'b1;
        else begin
          c.raw_seen = 1'b1; c.value_sub = U_MAIN;
        end
      end
      if (!cons && !gup && c.value_sub == U_STR) begin
        if (b != CH_QUOTE && b != CH_LF && b != CH_NUL) begin
          cons = 1'b1;
        end else begin
          c.content_seen  = 1'b1;
          c.space_waiting = 1'b0;
          c.last_was_word = 1'b0;
          c.value_sub     = U_MAIN;
          if (b == CH_QUOTE) cons = 1'b1;
        end
      end
      if (!cons && !gup && c.value_sub == U_MAIN) begin
        if (value_stop(b)) begin
          if (!c.raw_seen || !c.content_seen) gup = 1'b1;
          else begin
            me = pos_base; done = 1'b1; kind = TK_VALUE;
          end
        end else if (b == CH_QUOTE) begin
          cons = 1'b1; c.value_sub = U_STR;
        end else if (opens_bracket(b)) begin
          gup = 1'b1;
        end else begin
          if (b == CH_SLASH || b == CH_BSL || b == CH_COLON) c.raw_seen = 1'b1;
          if (is_blank(b)) begin
            c.space_waiting = c.content_seen;
          end else begin
            w = is_wordch(b);
            if (c.space_waiting && c.last_was_word && w) c.raw_seen = 1'b1;
            c.space_waiting = 1'b0;
            c.last_was_word = w;
            c.content_seen  = 1'b1;
          end
          cons = 1'b1;
        end
      end
      if (gup) done = 1'b1;
    end

    if (done) c = enter(c, PH_IDLE);

    ctl_next          = c;
    position_next     = cons ? pos_inc : pos_base;
    start_offset_next = skip ? pos_inc : so_base;
    marked_end_next   = me;
  end

  // result word
  always_comb begin
    res_valid = done;
    res_kind  = kind;
    res_start = (kind != TK_NONE) ? clamp16(so_base) : 16'd0;
    res_end   = (kind != TK_NONE) ? clamp16(me) : 16'd0;
  end

endmodule

/* design/script_token_boundary_scanner_core.sv */
// ----------------------------------------------------------------------------
// script_token_boundary_scanner_core: token boundary scanner top level
// Input register, one-byte scanner step, registered result word.
// ----------------------------------------------------------------------------
// One byte word is taken per clock cycle unless the input side stalls. Each
// word is captured in an input register and handled by the combinational
// scanner step; a result, when the scan attempt ends, is written from there
// into the output register, where token_valid rises. Throughput is one byte
// per cycle, since the step sits between the input and result registers; the
// input side stalls only when the byte in the input register would end a
// scan while the output register still holds an untaken result.
module script_token_boundary_scanner_core #(
  parameter int OFFSET_BITS = stbs_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic        scan_start,
  input  logic [2:0]  valid_kinds,
  input  logic [7:0]  char_code,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [1:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_end
);
  import stbs_pkg::*;

  // input register
  logic       iv;
  logic       i_start;
  logic [2:0] i_kinds;
  logic [7:0] i_char;

  // scanner state
  ctl_t                   ctl, ctl_next;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [OFFSET_BITS-1:0] marked_end, marked_end_next;

  // step result and output register
  logic        res_valid;
  kind_t       res_kind;
  logic [15:0] res_start, res_end;
  kind_t       tok_kind;
  logic        out_free, step_go;

  stbs_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
    .ctl               (ctl),
    .position          (position),
    .start_offset      (start_offset),
    .marked_end        (marked_end),
    .scan_start        (i_start),
    .valid_kinds       (i_kinds),
    .char_code         (i_char),
    .ctl_next          (ctl_next),
    .position_next     (position_next),
    .start_offset_next (start_offset_next),
    .marked_end_next   (marked_end_next),
    .res_valid         (res_valid),
    .res_kind          (res_kind),
    .res_start         (res_start),
    .res_end           (res_end)
  );

  assign out_free   = !token_valid || !token_stall;
  assign step_go    = iv && (!res_valid || out_free);
  assign char_stall = iv && !step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!char_stall) begin
      iv <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      i_start <= scan_start;
      i_kinds <= valid_kinds;
      i_char  <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= CTL_RESET;
      position     <= '0;
      start_offset <= '0;
      marked_end   <= '0;
    end else if (step_go) begin
      ctl          <= ctl_next;
      position     <= position_next;
      start_offset <= start_offset_next;
      marked_end   <= marked_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (step_go && res_valid) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && res_valid) begin
      tok_kind    <= res_kind;
      token_start <= res_start;
      token_end   <= res_end;
    end
  end

  assign token_kind = tok_kind;

endmodule
